@@ hdl/fclru_pkg.sv @@
// shared types and constants of the frame cache lru policy block
package fclru_pkg;

  localparam int TIME_BITS      = 20;
  localparam int CAP_BITS       = 5;
  localparam int LOW_BITS       = 3;    // t / 40 and t / 200 both start with t >> 3
  localparam int XQ_BITS        = TIME_BITS - LOW_BITS;
  localparam int RECIP_BITS     = 18;
  localparam int RECIP_SHIFT    = 22;
  localparam int PROD_BITS      = XQ_BITS + RECIP_BITS;
  localparam int QUOT_BITS      = PROD_BITS - RECIP_SHIFT;
  localparam int REM_BITS       = 5;
  localparam int ROW_BITS       = 32;
  localparam int ROW_SEL_BITS   = 5;
  localparam int QUEUE_SLOTS    = 2;
  localparam int CFG_INDEX_BITS = 1;

  // ceil(2^22 / 25): exact floor(x / 25) for every 17-bit x
  localparam logic [RECIP_BITS-1:0] RECIP_25 = 18'd167773;
  localparam logic [XQ_BITS-1:0]    DIV_25   = 17'd25;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_CAP     = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REGULAR_CAP = 1'b1;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_PERM = 2'd1,
    CLS_KEY  = 2'd2,
    CLS_REG  = 2'd3
  } class_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_PERM,
    B_LOOK,
    B_UPD
  } back_state_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] frame_time;
    logic                 save_regular;
  } req_t;

  typedef struct packed {
    logic                 store_new;
    logic [1:0]           class_code;
    logic                 refreshed;
    logic                 evicted;
    logic [TIME_BITS-1:0] evicted_time;
  } res_t;

  typedef struct packed {
    class_t               kind;
    logic [TIME_BITS-1:0] frame_time;
    logic [QUOT_BITS-1:0] perm_idx;
  } q_entry_t;

  typedef struct packed {
    logic look;
    logic update;
  } lru_ctl_t;

  typedef struct packed {
    logic                 hit;
    logic                 evict;
    logic [TIME_BITS-1:0] evict_time;
  } lru_res_t;

endpackage

@@ hdl/fclru_ram.sv @@
// generic single write port ram with registered read
module fclru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/fclru_front.sv @@
// front end: splits the frame time by 40 and 200 and queues a classified request
module fclru_front #(
  parameter int PERMANENT_SLOTS = 8192
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  fclru_pkg::req_t    req,
  output logic               front_busy,
  input  logic               q_full,
  output logic               q_push,
  output fclru_pkg::q_entry_t q_data
);

  localparam int QB = fclru_pkg::QUOT_BITS;
  localparam int XB = fclru_pkg::XQ_BITS;

  fclru_pkg::front_state_t state_r, state_nxt;

  logic [fclru_pkg::TIME_BITS-1:0]  time_r;
  logic                             save_r;
  logic [fclru_pkg::PROD_BITS-1:0]  prod_r;
  logic [QB-1:0]                    idx_r, idx_nxt;
  logic [fclru_pkg::REM_BITS-1:0]   rem_r;
  logic [XB-1:0]                    x_in;
  logic [QB-1:0]                    quot;
  logic [XB-1:0]                    rem_full;
  logic                             idx_big;
  logic                             low_zero;
  logic                             is_perm;
  logic                             is_key;
  fclru_pkg::class_t                kind;

  assign x_in     = req.frame_time[fclru_pkg::TIME_BITS-1:fclru_pkg::LOW_BITS];
  assign quot     = prod_r[fclru_pkg::RECIP_SHIFT +: QB];
  assign rem_full = time_r[fclru_pkg::TIME_BITS-1:fclru_pkg::LOW_BITS]
                    - XB'(quot) * fclru_pkg::DIV_25;
  assign idx_big  = 32'(idx_r) >= 32'(PERMANENT_SLOTS);

  // multiple of 200: low bits clear and (t >> 3) divisible by 25
  assign low_zero = time_r[fclru_pkg::LOW_BITS-1:0] == '0;
  assign is_perm  = low_zero && (rem_r == 5'd0);
  assign is_key   = low_zero && ((rem_r == 5'd5) || (rem_r == 5'd10) ||
                                 (rem_r == 5'd15) || (rem_r == 5'd20));

  always_comb begin
    priority if (is_perm) begin
      kind = fclru_pkg::CLS_PERM;
    end else if (is_key) begin
      kind = fclru_pkg::CLS_KEY;
    end else if (save_r) begin
      kind = fclru_pkg::CLS_REG;
    end else begin
      kind = fclru_pkg::CLS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fclru_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      time_r <= req.frame_time;
      save_r <= req.save_regular;
      prod_r <= fclru_pkg::PROD_BITS'(x_in) *
                fclru_pkg::PROD_BITS'(fclru_pkg::RECIP_25);
    end
    if (state_r == fclru_pkg::F_DIV) begin
      rem_r <= rem_full[fclru_pkg::REM_BITS-1:0];
    end
    idx_r <= idx_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    q_push    = 1'b0;
    unique case (state_r)
      fclru_pkg::F_IDLE: begin
        if (accept) begin
          state_nxt = fclru_pkg::F_DIV;
        end
      end
      fclru_pkg::F_DIV: begin
        idx_nxt   = quot;
        state_nxt = fclru_pkg::F_PUSH;
      end
      fclru_pkg::F_PUSH: begin
        // map index wraps over the slot count, one subtract a cycle
        if (idx_big) begin
          idx_nxt = idx_r - QB'(PERMANENT_SLOTS);
        end else if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = fclru_pkg::F_IDLE;
        end
      end
      default: begin
        state_nxt = fclru_pkg::F_IDLE;
      end
    endcase
  end

  assign front_busy        = state_r != fclru_pkg::F_IDLE;
  assign q_data.kind       = kind;
  assign q_data.frame_time = time_r;
  assign q_data.perm_idx   = idx_r;

  a_push_has_small_rem: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (rem_r < 5'd25) && !idx_big)
    else $error("front pushed with an unreduced remainder or index");

endmodule

@@ hdl/fclru_queue.sv @@
// two entry fifo between front and back
module fclru_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fclru_pkg::q_entry_t push_data,
  input  logic                pop,
  output fclru_pkg::q_entry_t head,
  output logic                full,
  output logic                empty
);

  localparam int PW = $clog2(fclru_pkg::QUEUE_SLOTS);
  localparam int CW = $clog2(fclru_pkg::QUEUE_SLOTS + 1);

  fclru_pkg::q_entry_t slot_r [fclru_pkg::QUEUE_SLOTS];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (32'(wptr_r) == fclru_pkg::QUEUE_SLOTS - 1) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (32'(rptr_r) == fclru_pkg::QUEUE_SLOTS - 1) ? '0 : rptr_r + 1'b1;
      end
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  assign head  = slot_r[rptr_r];
  assign full  = 32'(count_r) == fclru_pkg::QUEUE_SLOTS;
  assign empty = count_r == '0;

endmodule

@@ hdl/fclru_lru_set.sv @@
// one exact lru set: parallel compare, then shift toward the lru end
module fclru_lru_set #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fclru_pkg::lru_ctl_t               ctl,
  input  logic [fclru_pkg::TIME_BITS-1:0]   frame_time,
  input  logic [fclru_pkg::CAP_BITS-1:0]    cap,
  output fclru_pkg::lru_res_t               res
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [fclru_pkg::TIME_BITS-1:0] order_r [DEPTH];
  logic [CW-1:0]    count_r;
  logic [DEPTH-1:0] match_r, match_nxt, ge;
  logic             hit_r;
  logic [CW-1:0]    cap_eff;
  logic             evict;
  logic             shift;

  always_comb begin
    priority if (cap == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap);
    end
  end

  assign evict = !hit_r && (count_r >= cap_eff);
  assign shift = hit_r || evict;

  for (genvar j = 0; j < DEPTH; j++) begin : g_ent
    localparam logic [DEPTH-1:0] LOW_MASK = {DEPTH{1'b1}} >> (DEPTH - 1 - j);
    logic [fclru_pkg::TIME_BITS-1:0] upper;

    if (j == DEPTH - 1) begin : g_last
      assign upper = order_r[j];
    end else begin : g_mid
      assign upper = order_r[j+1];
    end

    assign match_nxt[j] = (order_r[j] == frame_time) && (CW'(j) < count_r);
    // at or above the hit position; all entries on an eviction
    assign ge[j] = hit_r ? |(match_r & LOW_MASK) : 1'b1;

    always_ff @(posedge clk) begin
      if (ctl.update) begin
        if (shift) begin
          if (CW'(j + 1) == count_r) begin
            order_r[j] <= frame_time;
          end else if (ge[j] && (CW'(j + 1) < count_r)) begin
            order_r[j] <= upper;
          end
        end else if (CW'(j) == count_r) begin
          order_r[j] <= frame_time;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      match_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (ctl.look) begin
        match_r <= match_nxt;
        hit_r   <= |match_nxt;
      end
      if (ctl.update && !shift) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  assign res.hit        = hit_r;
  assign res.evict      = evict;
  assign res.evict_time = order_r[0];

  a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_r))
    else $error("lru set holds a duplicate frame time");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH)
    else $error("lru count beyond depth");

  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.update && !shift) |=> (count_r == $past(count_r) + 1'b1))
    else $error("lru allocate without eviction did not grow the set");

endmodule

@@ hdl/fclru_back.sv @@
// back end: permanent bitmap and the two lru sets, one request at a time
module fclru_back #(
  parameter int QUEUE_DEPTH     = 16,
  parameter int PERMANENT_SLOTS = 8192
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [fclru_pkg::CAP_BITS-1:0] key_cap,
  input  logic [fclru_pkg::CAP_BITS-1:0] reg_cap,
  input  fclru_pkg::q_entry_t            head,
  input  logic                           q_empty,
  output logic                           q_pop,
  output logic                           clearing,
  output logic                           out_valid,
  output fclru_pkg::res_t                out_res
);

  localparam int ROWS = (PERMANENT_SLOTS + fclru_pkg::ROW_BITS - 1) / fclru_pkg::ROW_BITS;
  localparam int RAW  = $clog2(ROWS);
  localparam logic [RAW-1:0]                 LAST_ROW = RAW'(ROWS - 1);
  localparam logic [fclru_pkg::ROW_BITS-1:0] ONE_BIT  = 1;

  fclru_pkg::back_state_t state_r, state_nxt;
  fclru_pkg::q_entry_t    cur_r, cur_nxt;
  logic [RAW-1:0]         clr_addr_r, clr_addr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  fclru_pkg::res_t        out_res_r, out_res_nxt;

  logic                          ram_we, ram_re;
  logic [RAW-1:0]                ram_waddr, ram_raddr;
  logic [fclru_pkg::ROW_BITS-1:0] ram_wdata, ram_rdata;
  logic [fclru_pkg::ROW_SEL_BITS-1:0] bit_sel;
  logic                          bit_set;

  fclru_pkg::lru_ctl_t key_ctl, reg_ctl;
  fclru_pkg::lru_res_t key_res, reg_res, sel_res;

  fclru_ram #(
    .WIDTH (fclru_pkg::ROW_BITS),
    .DEPTH (ROWS)
  ) u_perm_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fclru_lru_set #(.DEPTH(QUEUE_DEPTH)) u_key_set (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (key_ctl),
    .frame_time (cur_r.frame_time),
    .cap        (key_cap),
    .res        (key_res)
  );

  fclru_lru_set #(.DEPTH(QUEUE_DEPTH)) u_reg_set (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (reg_ctl),
    .frame_time (cur_r.frame_time),
    .cap        (reg_cap),
    .res        (reg_res)
  );

  assign bit_sel = cur_r.perm_idx[fclru_pkg::ROW_SEL_BITS-1:0];
  assign bit_set = ram_rdata[bit_sel];
  assign sel_res = (cur_r.kind == fclru_pkg::CLS_KEY) ? key_res : reg_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fclru_pkg::B_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    out_res_r <= out_res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = RAW'(cur_r.perm_idx >> fclru_pkg::ROW_SEL_BITS);
    ram_wdata     = ram_rdata | (ONE_BIT << bit_sel);
    ram_re        = 1'b0;
    ram_raddr     = RAW'(head.perm_idx >> fclru_pkg::ROW_SEL_BITS);
    key_ctl       = '0;
    reg_ctl       = '0;
    unique case (state_r)
      fclru_pkg::B_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ROW) begin
          state_nxt = fclru_pkg::B_IDLE;
        end
      end
      fclru_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = head;
          unique case (head.kind)
            fclru_pkg::CLS_NONE: begin
              out_valid_nxt = 1'b1;
              out_res_nxt   = '0;
            end
            fclru_pkg::CLS_PERM: begin
              ram_re    = 1'b1;
              state_nxt = fclru_pkg::B_PERM;
            end
            fclru_pkg::CLS_KEY, fclru_pkg::CLS_REG: begin
              state_nxt = fclru_pkg::B_LOOK;
            end
            default: begin
              state_nxt = fclru_pkg::B_IDLE;
            end
          endcase
        end
      end
      fclru_pkg::B_PERM: begin
        ram_we                 = !bit_set;
        out_valid_nxt          = 1'b1;
        out_res_nxt            = '0;
        out_res_nxt.class_code = fclru_pkg::CLS_PERM;
        out_res_nxt.store_new  = !bit_set;
        state_nxt              = fclru_pkg::B_IDLE;
      end
      fclru_pkg::B_LOOK: begin
        key_ctl.look = cur_r.kind == fclru_pkg::CLS_KEY;
        reg_ctl.look = cur_r.kind == fclru_pkg::CLS_REG;
        state_nxt    = fclru_pkg::B_UPD;
      end
      fclru_pkg::B_UPD: begin
        key_ctl.update           = cur_r.kind == fclru_pkg::CLS_KEY;
        reg_ctl.update           = cur_r.kind == fclru_pkg::CLS_REG;
        out_valid_nxt            = 1'b1;
        out_res_nxt.class_code   = cur_r.kind;
        out_res_nxt.refreshed    = sel_res.hit;
        out_res_nxt.store_new    = !sel_res.hit;
        out_res_nxt.evicted      = sel_res.evict;
        out_res_nxt.evicted_time = sel_res.evict ? sel_res.evict_time : '0;
        state_nxt                = fclru_pkg::B_IDLE;
      end
      default: begin
        state_nxt = fclru_pkg::B_IDLE;
      end
    endcase
  end

  assign clearing  = state_r == fclru_pkg::B_CLEAR;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty && (state_r == fclru_pkg::B_IDLE))
    else $error("back popped an empty queue or while busy");

  a_perm_responds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fclru_pkg::B_PERM) |=> out_valid_r &&
      (out_res_r.class_code == fclru_pkg::CLS_PERM))
    else $error("permanent request gave no permanent result");

endmodule

@@ hdl/frame_cache_lru_policy.sv @@
// top level of the frame cache lru policy block
//
//  channel   ports                          direction  transfer
//  request   start, busy, in_req            in         start && !busy
//  result    out_valid, out_res             out        out_valid, one cycle
//  config    cfg_we, cfg_index, cfg_wdata   in         cfg_we, no wait
//
//  a request is multiplied by the reciprocal of 25 when taken, then the front
//  forms the remainder and classifies, subtracting PERMANENT_SLOTS while the
//  permanent index is not below it, then waits in a two entry queue
//  the back answers an uncached frame in the cycle after its pop, a permanent
//  frame by a bitmap row read, then write, and an lru frame by pop, compare, shift
//  busy is high while the front holds a request and during the bitmap clear
//  after reset, which writes one 32-bit row a cycle, ceil(PERMANENT_SLOTS/32)
//  rows in all; results come out in request order and cannot be held off
module frame_cache_lru_policy #(
  parameter int QUEUE_DEPTH     = 16,
  parameter int PERMANENT_SLOTS = 8192
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  fclru_pkg::req_t                      in_req,
  output logic                                 out_valid,
  output fclru_pkg::res_t                      out_res,
  input  logic                                 cfg_we,
  input  logic [fclru_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [fclru_pkg::CAP_BITS-1:0]       cfg_wdata
);

  // capacity registers, out-of-range values are clamped inside each set
  logic [fclru_pkg::CAP_BITS-1:0] key_cap_r, key_cap_nxt;
  logic [fclru_pkg::CAP_BITS-1:0] reg_cap_r, reg_cap_nxt;

  logic                accept;
  logic                front_busy;
  logic                clearing;
  logic                q_push, q_pop, q_full, q_empty;
  fclru_pkg::q_entry_t q_in, q_head;

  // a request is taken only when the front is free and the bitmap is clear
  assign busy   = front_busy || clearing;
  assign accept = start && !busy;

  always_comb begin
    key_cap_nxt = key_cap_r;
    reg_cap_nxt = reg_cap_r;
    if (cfg_we) begin
      unique case (cfg_index)
        fclru_pkg::REG_KEY_CAP:     key_cap_nxt = cfg_wdata;
        fclru_pkg::REG_REGULAR_CAP: reg_cap_nxt = cfg_wdata;
        default: begin
          key_cap_nxt = key_cap_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_cap_r <= fclru_pkg::CAP_RESET;
      reg_cap_r <= fclru_pkg::CAP_RESET;
    end else begin
      key_cap_r <= key_cap_nxt;
      reg_cap_r <= reg_cap_nxt;
    end
  end

  // front: divide and classify
  fclru_front #(.PERMANENT_SLOTS(PERMANENT_SLOTS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .req        (in_req),
    .front_busy (front_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  // decouples the divide from the set updates
  fclru_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: bitmap and lru sets, owns the result register
  fclru_back #(
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .PERMANENT_SLOTS (PERMANENT_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_cap   (key_cap_r),
    .reg_cap   (reg_cap_r),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the frame cache lru policy block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LRU_DEPTH   = 16;
  localparam int PERM_SLOTS  = 8192;
  localparam int KEY_PERIOD  = 40;
  localparam int PERM_PERIOD = 200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 5;
  localparam int RAND_ITEMS  = 100;
  localparam int POOL_SIZE   = 24;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 start = 1'b0;
  logic                                 busy;
  fclru_pkg::req_t                      in_req = '0;
  logic                                 out_valid;
  fclru_pkg::res_t                      out_res;
  logic                                 cfg_we = 1'b0;
  logic [fclru_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [fclru_pkg::CAP_BITS-1:0]       cfg_wdata = '0;

  // requests waiting to be driven, and decisions waiting to come out
  fclru_pkg::req_t pending_reqs[$];
  fclru_pkg::res_t expected_decisions[$];

  // shadow of the block: capacities and the two lru sets are indexed by the
  // register index of their capacity, index 0 of each set is least recent
  logic [fclru_pkg::CAP_BITS-1:0]  lru_cap [2];
  logic [fclru_pkg::TIME_BITS-1:0] lru_order [2][LRU_DEPTH];
  int unsigned                     lru_count [2];
  bit                              perm_stored [PERM_SLOTS];

  logic [fclru_pkg::TIME_BITS-1:0] regular_pool [POOL_SIZE];
  int unsigned          key_base;
  bit                   steady_flow;
  bit                   failed;
  int unsigned          cycles;

  frame_cache_lru_policy #(
    .QUEUE_DEPTH    (LRU_DEPTH),
    .PERMANENT_SLOTS(PERM_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // touch one lru set: a hit moves the entry to the most recent end, a miss
  // appends it, dropping the least recent entry first once the set is full
  function automatic void touch_lru(input logic [fclru_pkg::CFG_INDEX_BITS-1:0] set_id,
                                    input logic [fclru_pkg::TIME_BITS-1:0] t,
                                    output logic hit, output logic ev,
                                    output logic [fclru_pkg::TIME_BITS-1:0] ev_time);
    int unsigned n;
    int unsigned pos;
    int unsigned cap;
    n = lru_count[set_id];
    pos = n;
    hit = 1'b0;
    ev = 1'b0;
    ev_time = '0;
    // capacity 0 behaves as 1, anything past the depth as the depth
    cap = 32'(lru_cap[set_id]);
    if (cap == 0) cap = 1;
    if (cap > LRU_DEPTH) cap = LRU_DEPTH;
    for (int i = 0; i < n; i++) begin
      if (pos == n && lru_order[set_id][i] == t) pos = i;
    end
    if (pos < n) begin
      hit = 1'b1;
      for (int i = pos; i + 1 < n; i++) lru_order[set_id][i] = lru_order[set_id][i+1];
      lru_order[set_id][n-1] = t;
    end else if (n < cap) begin
      lru_order[set_id][n] = t;
      lru_count[set_id] = n + 1;
    end else begin
      // a lowered capacity keeps the count: one out, one in
      ev = 1'b1;
      ev_time = lru_order[set_id][0];
      for (int i = 0; i + 1 < n; i++) lru_order[set_id][i] = lru_order[set_id][i+1];
      lru_order[set_id][n-1] = t;
    end
  endfunction

  // decision for one request, updating the shadow state
  function automatic fclru_pkg::res_t predict_policy(input fclru_pkg::req_t r);
    fclru_pkg::res_t                      res;
    logic [fclru_pkg::TIME_BITS-1:0]      t;
    int unsigned                          slot;
    logic                                 hit;
    logic                                 ev;
    logic [fclru_pkg::TIME_BITS-1:0]      ev_time;
    logic [fclru_pkg::CFG_INDEX_BITS-1:0] set_id;
    res = '0;
    t = r.frame_time;
    if (t % PERM_PERIOD == 0) begin
      // permanent frames never touch the lru sets
      slot = (t / PERM_PERIOD) % PERM_SLOTS;
      res.class_code = fclru_pkg::CLS_PERM;
      if (!perm_stored[slot]) begin
        perm_stored[slot] = 1'b1;
        res.store_new = 1'b1;
      end
    end else if (t % KEY_PERIOD == 0 || r.save_regular) begin
      set_id = (t % KEY_PERIOD == 0) ? fclru_pkg::REG_KEY_CAP : fclru_pkg::REG_REGULAR_CAP;
      touch_lru(set_id, t, hit, ev, ev_time);
      res.class_code = (set_id == fclru_pkg::REG_KEY_CAP) ? fclru_pkg::CLS_KEY
                                                          : fclru_pkg::CLS_REG;
      res.refreshed = hit;
      res.store_new = !hit;
      res.evicted = ev;
      res.evicted_time = ev_time;
    end
    // otherwise the frame is not eligible and the decision is all zero
    return res;
  endfunction

  // random request: mostly times from small key and regular working sets so
  // that hits, misses and evictions all show up, plus permanent frames and
  // full-width noise
  function automatic fclru_pkg::req_t random_frame();
    fclru_pkg::req_t r;
    int unsigned     roll;
    int unsigned     v;
    roll = $urandom_range(0, 99);
    r.save_regular = 1'($urandom_range(0, 1));
    if (roll < 35) begin
      v = KEY_PERIOD * (key_base + $urandom_range(1, 24));
    end else if (roll < 70) begin
      v = 32'(regular_pool[$urandom_range(0, POOL_SIZE - 1)]);
      r.save_regular = ($urandom_range(0, 9) != 0);
    end else if (roll < 76) begin
      v = PERM_PERIOD * $urandom_range(0, 20);
    end else if (roll < 82) begin
      v = PERM_PERIOD * $urandom_range(0, 5242);
    end else begin
      v = $urandom;
    end
    r.frame_time = v[fclru_pkg::TIME_BITS-1:0];
    return r;
  endfunction

  // request driver: holds start until the handshake, then either chains the
  // next request right away or idles for a random gap
  always @(posedge clk) begin : drive_requests
    int unsigned roll;
    int unsigned gap;
    int unsigned idle_left;
    if (!rst_n) begin
      start <= 1'b0;
      in_req <= '0;
      idle_left = 0;
    end else if (start && !busy) begin
      expected_decisions = {expected_decisions, predict_policy(in_req)};
      roll = $urandom_range(0, 99);
      // mostly short gaps, a few long ones, none at all in a steady phase
      if (steady_flow || roll < 55) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(6, 25);
      if (gap == 0 && pending_reqs.size() != 0) begin
        in_req <= pending_reqs.pop_front();
      end else begin
        start <= 1'b0;
        idle_left = gap;
      end
    end else if (!start) begin
      if (idle_left != 0) begin
        idle_left = idle_left - 1;
      end else if (pending_reqs.size() != 0) begin
        in_req <= pending_reqs.pop_front();
        start <= 1'b1;
      end
    end
  end

  // decision monitor: every strobe must match the oldest prediction
  always @(posedge clk) begin : check_decisions
    fclru_pkg::res_t want;
    if (rst_n && out_valid) begin
      if (expected_decisions.size() == 0) begin
        $error("unexpected decision: time %0d class %0d", out_res.evicted_time,
               out_res.class_code);
        failed = 1'b1;
      end else begin
        want = expected_decisions.pop_front();
        if (out_res.store_new !== want.store_new) begin
          $error("store_new: expected %0d, got %0d", want.store_new, out_res.store_new);
          failed = 1'b1;
        end
        if (out_res.class_code !== want.class_code) begin
          $error("class_code: expected %0d, got %0d", want.class_code, out_res.class_code);
          failed = 1'b1;
        end
        if (out_res.refreshed !== want.refreshed) begin
          $error("refreshed: expected %0d, got %0d", want.refreshed, out_res.refreshed);
          failed = 1'b1;
        end
        if (out_res.evicted !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, out_res.evicted);
          failed = 1'b1;
        end
        if (out_res.evicted_time !== want.evicted_time) begin
          $error("evicted_time: expected %0d, got %0d", want.evicted_time,
                 out_res.evicted_time);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // capacity write, only issued while nothing is in flight
  task automatic write_cap(input logic [fclru_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [fclru_pkg::CAP_BITS-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    lru_cap[idx] = value;
  endtask

  // block is idle once every request went in and every decision came out
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || start || expected_decisions.size() != 0);
  endtask

  task automatic queue_req(input int unsigned t, input bit save_regular);
    fclru_pkg::req_t r;
    r.frame_time = t[fclru_pkg::TIME_BITS-1:0];
    r.save_regular = save_regular;
    pending_reqs = {pending_reqs, r};
  endtask

  initial begin : run_test
    int unsigned t;
    lru_cap[fclru_pkg::REG_KEY_CAP] = fclru_pkg::CAP_RESET;
    lru_cap[fclru_pkg::REG_REGULAR_CAP] = fclru_pkg::CAP_RESET;
    lru_count[fclru_pkg::REG_KEY_CAP] = 0;
    lru_count[fclru_pkg::REG_REGULAR_CAP] = 0;
    key_base = 0;
    steady_flow = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      t = $urandom_range(1, (1 << fclru_pkg::TIME_BITS) - 1);
      if (t % KEY_PERIOD == 0) t = t - 1;
      regular_pool[i] = t[fclru_pkg::TIME_BITS-1:0];
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset capacities: permanent new and already stored, top of range,
    // not eligible, regular and key allocation and refresh
    queue_req(0, 1'b0);
    queue_req(0, 1'b1);
    queue_req(1048400, 1'b0);
    queue_req(1048575, 1'b0);
    queue_req(1048575, 1'b1);
    queue_req(1048575, 1'b1);
    queue_req(40, 1'b0);
    queue_req(80, 1'b1);
    queue_req(40, 1'b0);
    queue_req(120, 1'b0);
    queue_req(160, 1'b0);
    queue_req(240, 1'b0);
    queue_req(1, 1'b1);
    queue_req(2, 1'b1);
    queue_req(39, 1'b1);
    wait_drained();

    // capacities below the current counts, and zero acting as one
    write_cap(fclru_pkg::REG_KEY_CAP, 5'd2);
    write_cap(fclru_pkg::REG_REGULAR_CAP, 5'd0);
    queue_req(280, 1'b0);
    queue_req(40, 1'b0);
    queue_req(1, 1'b1);
    queue_req(3, 1'b1);
    queue_req(5, 1'b1);
    queue_req(41, 1'b0);
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      unique case (ph)
        0: begin
          write_cap(fclru_pkg::REG_KEY_CAP, 5'd31);
          write_cap(fclru_pkg::REG_REGULAR_CAP, 5'd31);
        end
        1: begin
          write_cap(fclru_pkg::REG_KEY_CAP, 5'd1);
          write_cap(fclru_pkg::REG_REGULAR_CAP, 5'd1);
        end
        2: begin
          write_cap(fclru_pkg::REG_KEY_CAP, 5'd16);
          write_cap(fclru_pkg::REG_REGULAR_CAP, 5'd16);
        end
        3: begin
          write_cap(fclru_pkg::REG_KEY_CAP, 5'd3);
          write_cap(fclru_pkg::REG_REGULAR_CAP, 5'd5);
        end
        default: begin
          write_cap(fclru_pkg::REG_KEY_CAP, 5'($urandom_range(0, 31)));
          write_cap(fclru_pkg::REG_REGULAR_CAP, 5'($urandom_range(0, 31)));
        end
      endcase
      // key times near the bottom or the top of the time range
      key_base = (ph % 2 == 1) ? 26190 : 0;
      steady_flow = (ph == 2);
      repeat (RAND_ITEMS) pending_reqs = {pending_reqs, random_frame()};
      wait_drained();
    end

    // tail: catch any stray decision
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/fclru_pkg.sv
hdl/fclru_ram.sv
hdl/fclru_front.sv
hdl/fclru_queue.sv
hdl/fclru_lru_set.sv
hdl/fclru_back.sv
hdl/frame_cache_lru_policy.sv
verif/testbench.sv
